@@ hw/rtl/sleep_period_scheduler_macros.svh @@
// assertion macros for the sleep period scheduler
`ifndef SLEEP_PERIOD_SCHEDULER_MACROS_SVH
`define SLEEP_PERIOD_SCHEDULER_MACROS_SVH

// condition and consequence in the same cycle
`define SPS_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence in the cycle after the condition
`define SPS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/sps_pkg.sv @@
package sps_pkg;

    // field widths
    localparam int DUR_W  = 32;
    localparam int LINE_W = 8;
    localparam int EXP_W  = 4;

    // stream widths
    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 2;
    localparam int OUT_BITS   = 49;
    localparam int OUT_DATA_W = 56;

    // constants of the scheduling rule
    localparam logic [LINE_W-1:0] NO_LINE   = 8'd255;
    localparam logic [EXP_W-1:0]  MIN_EXP   = 4'd3;
    localparam logic [EXP_W-1:0]  MAX_EXP   = 4'd14;
    localparam logic [DUR_W-1:0]  ROUND_UP  = 32'd15;
    localparam logic [DUR_W-1:0]  MIN_LEFT  = 32'd16;
    localparam logic [DUR_W-1:0]  DUR_MAX   = 32'hFFFF_FFFF;

    // item kinds
    typedef enum logic [1:0] {
        MODE_START    = 2'd0,
        MODE_ELAPSED  = 2'd1,
        MODE_LINE_ONE = 2'd2,
        MODE_LINE_TWO = 2'd3
    } mode_t;

    // wake reasons
    typedef enum logic [1:0] {
        REASON_NONE  = 2'd0,
        REASON_TIMER = 2'd1,
        REASON_LINE  = 2'd2
    } reason_t;

    // input item
    typedef struct packed {
        mode_t             mode;
        logic [LINE_W-1:0] second_line_number;
        logic [LINE_W-1:0] first_line_number;
        logic [DUR_W-1:0]  duration_ms;
    } in_item_t;

    // result item, first field in the highest bits
    typedef struct packed {
        logic [DUR_W-1:0]  remaining_ms;
        logic [LINE_W-1:0] wake_line;
        reason_t           wake_reason;
        logic              finished;
        logic              sleeping;
        logic [EXP_W-1:0]  period_code;
        logic              arm_timer;
    } out_item_t;

    // largest period exponent from MIN_EXP to MAX_EXP not above ms
    function automatic logic [EXP_W-1:0] pick_exponent(input logic [DUR_W-1:0] ms);
        logic [EXP_W-1:0] p;
        p = MIN_EXP;
        for (int i = int'(MIN_EXP) + 1; i <= int'(MAX_EXP); i++)
        begin
            if (|(ms >> i))
            begin
                p = EXP_W'(i);
            end
        end
        return p;
    endfunction

endpackage

@@ hw/rtl/sleep_period_scheduler.sv @@
// Sleep period scheduler. Each input item (a start, an elapsed period or a wake line
// event, kind in s_tuser) gives exactly one result item. The block takes one item per
// clock cycle while the result register does not stall; an accepted item passes the
// input register and then the result register. The sleep state is read and updated
// as the item moves from the input register to the result register, so consecutive
// items see each other's effect with no gap. A stalled result register holds the
// input register, and s_tready is low while it does.
`include "sleep_period_scheduler_macros.svh"

module sleep_period_scheduler
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // duration_ms, first_line_number, second_line_number
    input  logic [sps_pkg::IN_DATA_W-1:0]   s_tdata,
    // mode
    input  logic [sps_pkg::IN_USER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // arm_timer, period_code, sleeping, finished, wake_reason, wake_line,
    // remaining_ms, zero fill
    output logic [sps_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import sps_pkg::*;

    // input register
    in_item_t          s1_item_reg;
    logic              s1_valid_reg;
    // result register
    out_item_t         out_item_reg;
    out_item_t         out_item_next;
    logic              out_valid_reg;
    // sleep state
    logic [DUR_W-1:0]  left_reg,     left_next;
    logic [EXP_W-1:0]  exp_reg,      exp_next;
    logic              busy_reg,     busy_next;
    logic              endless_reg,  endless_next;
    logic [LINE_W-1:0] line_one_reg, line_one_next;
    logic [LINE_W-1:0] line_two_reg, line_two_next;

    logic              out_free;
    logic              s1_fire;
    logic              in_fire;
    logic [DUR_W:0]    sum_start;
    logic [DUR_W-1:0]  start_left;
    logic [DUR_W-1:0]  period;
    logic [DUR_W-1:0]  after_period;
    logic [LINE_W-1:0] event_line;

    // handshake
    assign out_free = !out_valid_reg || m_tready;
    assign s1_fire  = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_DATA_W - OUT_BITS)'(0), out_item_reg};

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg <= {mode_t'(s_tuser), s_tdata};
        end
    end

    // shared arithmetic
    assign sum_start    = {1'b0, s1_item_reg.duration_ms} + {1'b0, ROUND_UP};
    assign start_left   = sum_start[DUR_W] ? DUR_MAX : sum_start[DUR_W-1:0];
    assign period       = DUR_W'(1) << exp_reg;
    assign after_period = (left_reg >= period) ? (left_reg - period) : '0;
    assign event_line   = (s1_item_reg.mode == MODE_LINE_ONE) ? line_one_reg : line_two_reg;

    // scheduling step
    always_comb
    begin
        left_next     = left_reg;
        exp_next      = exp_reg;
        busy_next     = busy_reg;
        endless_next  = endless_reg;
        line_one_next = line_one_reg;
        line_two_next = line_two_reg;
        out_item_next = '{remaining_ms: '0, wake_line: NO_LINE, wake_reason: REASON_NONE,
                          finished: 1'b0, sleeping: 1'b0, period_code: '0, arm_timer: 1'b0};

        case (s1_item_reg.mode)
            MODE_START:
            begin
                line_one_next = s1_item_reg.first_line_number;
                line_two_next = s1_item_reg.second_line_number;
                busy_next     = 1'b1;
                if (s1_item_reg.duration_ms == '0)
                begin
                    endless_next = 1'b1;
                    left_next    = '0;
                end
                else
                begin
                    endless_next = 1'b0;
                    left_next    = start_left;
                    if (start_left >= MIN_LEFT)
                    begin
                        exp_next                = pick_exponent(start_left);
                        out_item_next.arm_timer = 1'b1;
                    end
                    else
                    begin
                        busy_next                 = 1'b0;
                        out_item_next.finished    = 1'b1;
                        out_item_next.wake_reason = REASON_TIMER;
                    end
                end
            end
            MODE_ELAPSED:
            begin
                if (busy_reg && !endless_reg)
                begin
                    left_next = after_period;
                    if (after_period >= MIN_LEFT)
                    begin
                        exp_next                = pick_exponent(after_period);
                        out_item_next.arm_timer = 1'b1;
                    end
                    else
                    begin
                        busy_next                 = 1'b0;
                        out_item_next.finished    = 1'b1;
                        out_item_next.wake_reason = REASON_TIMER;
                    end
                end
            end
            MODE_LINE_ONE, MODE_LINE_TWO:
            begin
                if (busy_reg && (event_line != NO_LINE))
                begin
                    if (!endless_reg)
                    begin
                        left_next                  = after_period;
                        out_item_next.remaining_ms = after_period;
                    end
                    busy_next                 = 1'b0;
                    endless_next              = 1'b0;
                    out_item_next.finished    = 1'b1;
                    out_item_next.wake_reason = REASON_LINE;
                    out_item_next.wake_line   = event_line;
                end
            end
            default:
            begin
            end
        endcase

        out_item_next.period_code = exp_next;
        out_item_next.sleeping    = busy_next;
    end

    // sleep state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            exp_reg       <= MIN_EXP;
            busy_reg      <= 1'b0;
            endless_reg   <= 1'b0;
            line_one_reg  <= NO_LINE;
            line_two_reg  <= NO_LINE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_fire)
            begin
                left_reg     <= left_next;
                exp_reg      <= exp_next;
                busy_reg     <= busy_next;
                endless_reg  <= endless_next;
                line_one_reg <= line_one_next;
                line_two_reg <= line_two_next;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_item_reg <= out_item_next;
        end
    end

    // checks
    `SPS_ASSERT_NOW(a_endless_busy, endless_reg, busy_reg, "endless sleep while not busy")
    `SPS_ASSERT_NOW(a_timed_left, busy_reg && !endless_reg, left_reg >= MIN_LEFT,
                    "timed sleep with remainder below minimum")
    `SPS_ASSERT_NOW(a_arm_sleeping, out_valid_reg && out_item_reg.arm_timer,
                    out_item_reg.sleeping && !out_item_reg.finished,
                    "period armed on a result that is not sleeping")
    `SPS_ASSERT_NEXT(a_accept_held, in_fire, s1_valid_reg, "accepted item lost")

endmodule
